@@ rtl/otsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otsa_pkg
// Types and constants shared by the slot allocator cells and the top level.
// ----------------------------------------------------------------------------
package otsa_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int ID_WIDTH_DEF  = 32;

    localparam int REQ_W      = 2;
    localparam int OWNER_IN_W = 32;
    localparam int IDX_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_MARK       = 2'd2,
        REQ_ROLLBACK   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // request word as it travels down the cell chain
    typedef struct packed {
        logic             valid;
        t_req             req;
        logic [IDX_W-1:0] idx;
        logic             done;
        t_status          status;
        logic [IDX_W-1:0] res;
    } t_pkt;

endpackage : otsa_pkg
`default_nettype wire

@@ rtl/owner_tagged_slot_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owner_tagged_slot_allocator
// Slot table with owner tags and rollback marks, built as a chain of cells.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser req_type, tdata owner/index
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata status/result_index
//  cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_data slots_in_use
//
//  a request word walks the chain one cell per cycle while the output does not stall
//  a new word is taken every cycle while the result side keeps up
//  the last cell's word register is the output register
//  an output stall freezes the whole chain, so no word is lost or reordered
//  reset clears all valid bits and marks at once; owner tags need no reset
// ----------------------------------------------------------------------------
module owner_tagged_slot_allocator #(
    parameter int MAX_SLOTS = otsa_pkg::MAX_SLOTS_DEF,
    parameter int ID_WIDTH  = otsa_pkg::ID_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] owner_id, [35:32] slot_index, [39:36] zero
    input  wire [otsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] req_type
    input  wire [otsa_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [1:0] status, [5:2] result_index, [7:6] zero
    output logic [otsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [otsa_pkg::CFG_W-1:0]        i_cfg_data
);
    import otsa_pkg::*;

    logic [CFG_W-1:0]    r_count;
    logic                w_adv;
    t_pkt                w_pkt [MAX_SLOTS+1];
    logic [ID_WIDTH-1:0] w_own [MAX_SLOTS+1];
    logic [63:0]         w_owner_ext;
    t_pkt                w_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    assign w_last        = w_pkt[MAX_SLOTS];
    assign w_adv         = !w_last.valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // only the low ID_WIDTH bits of the owner are kept
    assign w_owner_ext = {32'd0, s_axis_tdata[OWNER_IN_W-1:0]};
    assign w_own[0]    = w_owner_ext[ID_WIDTH-1:0];

    always_comb begin
        w_pkt[0].valid = s_axis_tvalid;
        w_pkt[0].req   = t_req'(s_axis_tuser);
        w_pkt[0].idx   = s_axis_tdata[OWNER_IN_W +: IDX_W];
        w_pkt[0].done  = 1'b0;
        w_pkt[0].res   = '0;
        unique case (w_pkt[0].req)
            REQ_REGISTER:   w_pkt[0].status = ST_FULL;
            REQ_UNREGISTER: w_pkt[0].status = ST_RANGE;
            REQ_MARK:       w_pkt[0].status = ST_OK;
            REQ_ROLLBACK:   w_pkt[0].status = ST_NOTFOUND;
            default:        w_pkt[0].status = ST_OK;
        endcase
    end

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        otsa_cell #(
            .INDEX    (g),
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_count (r_count),
            .i_pkt   (w_pkt[g]),
            .i_owner (w_own[g]),
            .o_pkt   (w_pkt[g+1]),
            .o_owner (w_own[g+1])
        );
    end

    assign m_axis_tvalid = w_last.valid;
    assign m_axis_tdata  = {2'b00, w_last.res, w_last.status};

    a_res_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_last.status != ST_OK)) |-> (w_last.res == '0))
        else $error("result index set on a failed request");

    a_done_matches_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((w_last.req == REQ_REGISTER) || (w_last.req == REQ_ROLLBACK)))
        |-> (w_last.done == (w_last.status == ST_OK)))
        else $error("slot claim and status disagree");

    a_stall_freezes_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_pkt[1]))
        else $error("chain moved during an output stall");

endmodule : owner_tagged_slot_allocator
`default_nettype wire

@@ rtl/otsa_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otsa_cell
// One slot of the table: valid bit, owner tag and rollback mark. Applies the
// passing request word to its slot and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module otsa_cell #(
    parameter int INDEX    = 0,
    parameter int ID_WIDTH = otsa_pkg::ID_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_adv,
    input  wire [otsa_pkg::CFG_W-1:0]    i_count,
    input  otsa_pkg::t_pkt               i_pkt,
    input  wire [ID_WIDTH-1:0]           i_owner,
    output otsa_pkg::t_pkt               o_pkt,
    output logic [ID_WIDTH-1:0]          o_owner
);
    import otsa_pkg::*;

    localparam logic [IDX_W-1:0] RES = IDX_W'(INDEX);

    logic                r_valid;
    logic                r_mark;
    logic [ID_WIDTH-1:0] r_owner;
    t_pkt                r_pkt;
    logic [ID_WIDTH-1:0] r_owner_pass;

    logic n_valid;
    logic n_mark;
    t_pkt n_pkt;
    logic w_wr_owner;
    logic w_active;
    logic w_match;

    always_comb begin
        w_active   = (32'(INDEX) < 32'(i_count));
        w_match    = r_valid && (r_owner == i_owner);
        n_valid    = r_valid;
        n_mark     = r_mark;
        n_pkt      = i_pkt;
        w_wr_owner = 1'b0;
        if (i_pkt.valid && w_active) begin
            case (i_pkt.req)
                REQ_REGISTER: begin
                    // first free slot claims the word
                    if (!i_pkt.done && !r_valid) begin
                        n_valid      = 1'b1;
                        n_mark       = 1'b0;
                        w_wr_owner   = 1'b1;
                        n_pkt.done   = 1'b1;
                        n_pkt.status = ST_OK;
                        n_pkt.res    = RES;
                    end
                end
                REQ_UNREGISTER: begin
                    if (32'(i_pkt.idx) == 32'(INDEX)) begin
                        n_valid      = 1'b0;
                        n_mark       = 1'b0;
                        n_pkt.status = ST_OK;
                    end
                end
                REQ_MARK: begin
                    if (w_match) begin
                        n_mark = 1'b1;
                    end
                end
                REQ_ROLLBACK: begin
                    if (!i_pkt.done && w_match && r_mark) begin
                        n_valid      = 1'b0;
                        n_mark       = 1'b0;
                        n_pkt.done   = 1'b1;
                        n_pkt.status = ST_OK;
                        n_pkt.res    = RES;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
            r_pkt   <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_mark  <= n_mark;
            r_pkt   <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_owner_pass <= i_owner;
            if (w_wr_owner) begin
                r_owner <= i_owner;
            end
        end
    end

    assign o_pkt   = r_pkt;
    assign o_owner = r_owner_pass;

    a_mark_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark |-> r_valid)
        else $error("rollback mark set on a free slot");

endmodule : otsa_cell
`default_nettype wire
